[sv/cle_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pkg - shared types and constants for the leader election engine
// Role, op and register codes, sequencer states, modulo unit status.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int TERM_W  = 32;
  localparam int ID_W    = 16;
  localparam int TMO_W   = 16;
  localparam int CNT_W   = 5;
  localparam int SPAN_W  = TMO_W + 1;

  localparam logic [1:0] ROLE_FOLLOWER  = 2'd0;
  localparam logic [1:0] ROLE_CANDIDATE = 2'd1;
  localparam logic [1:0] ROLE_LEADER    = 2'd2;

  localparam logic [1:0] OP_TICK      = 2'd0;
  localparam logic [1:0] OP_VOTE_REQ  = 2'd1;
  localparam logic [1:0] OP_VOTE_RESP = 2'd2;
  localparam logic [1:0] OP_HEARTBEAT = 2'd3;

  localparam logic [1:0] CFG_TIMEOUT_MIN = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT_MAX = 2'd1;
  localparam logic [1:0] CFG_OWN_ID      = 2'd2;

  localparam logic [CNT_W-1:0] TALLY_MAX = 5'd31;
  localparam logic [TERM_W-1:0] TERM_MAX = 32'hFFFF_FFFF;

  localparam logic [TMO_W-1:0] TIMEOUT_MIN_RST = 16'd150;
  localparam logic [TMO_W-1:0] TIMEOUT_MAX_RST = 16'd300;
  localparam logic [ID_W-1:0]  OWN_ID_RST      = 16'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MOD,
    ST_DONE
  } cle_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cle_mod_stat_t;

endpackage

[sv/consensus_leader_election.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// consensus_leader_election - Raft-style election engine
// Keeps role, term, vote, tally and election countdown; one result per beat.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per event. in_tuser carries the op (tick, vote request,
//           vote response, heartbeat); in_tdata carries the message fields.
//   out_* : exactly one result beat per input beat, in order, holding the
//           role, term, vote, leader and the three event flags.
//   cfg_* : register writes (timeout min, timeout max, own id), always
//           ready; write only while the engine is idle.
// Sequence: an accepted beat is evaluated in ST_EVAL; when a timeout rearm
//   is needed, ST_MOD computes draw mod span in a serial remainder unit that
//   shifts in one dividend bit per step and then waits for its done flag;
//   ST_DONE loads the result into the output register.
// Flow: one beat at a time; in_tready is high only in the idle state, so no
//   new beat is accepted until the last result is loaded, which a stall delays.
// Reset: rst_n synchronous, active low. Role follower, term, vote, tally,
//   needed and leader zero, countdown at the timeout minimum reset (150).
// Stall: a result waits in the output register; the engine holds its next
//   result until that register is free and takes no new beat meanwhile.
// ----------------------------------------------------------------------------
module consensus_leader_election #(
  parameter int MAX_NODES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // op[1:0]
  input  logic [1:0]  in_tuser,
  // peer_id[15:0], msg_term[47:16], cand_last_index[79:48],
  // cand_last_term[111:80], peer_granted[112], own_last_index[144:113],
  // own_last_term[176:145], alive_count[181:177], random_draw[197:182],
  // zero pad[199:198]
  input  logic [199:0] in_tdata,
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // role[1:0], term_now[33:2], vote_cast_for[49:34], leader_now[65:50],
  // granted[66], election_started[67], leader_changed[68], pad[71:69]
  output logic [71:0] out_tdata,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import cle_pkg::*;

  localparam logic [CNT_W-1:0] MaxNodes = CNT_W'(MAX_NODES);

  // configuration registers
  logic [TMO_W-1:0] tmo_min_r, tmo_max_r;
  logic [ID_W-1:0]  own_id_r;

  // engine state
  logic [1:0]        role_r, role_nxt;
  logic [TERM_W-1:0] term_r, term_nxt;
  logic [ID_W-1:0]   voted_r, voted_nxt;
  logic [CNT_W-1:0]  tally_r, tally_nxt;
  logic [CNT_W-1:0]  needed_r, needed_nxt;
  logic [ID_W-1:0]   leader_r, leader_nxt;
  logic [TMO_W-1:0]  cdown_r, cdown_nxt;
  logic              granted_r, granted_nxt;
  logic              started_r, started_nxt;
  logic              changed_r, changed_nxt;
  logic              rearm;

  // latched beat
  logic [1:0]        op_r;
  logic [ID_W-1:0]   peer_r;
  logic [TERM_W-1:0] mterm_r, cidx_r, cterm_r, oidx_r, oterm_r;
  logic              pgrant_r;
  logic [CNT_W-1:0]  alive_r;
  logic [TMO_W-1:0]  draw_r;

  cle_state_t state_r, state_nxt;

  logic              out_tvalid_r, out_tvalid_nxt;
  logic [71:0]       out_tdata_r;
  logic              out_load;

  // modulo unit
  logic              mod_start;
  logic [SPAN_W-1:0] span;
  cle_mod_stat_t     mod_stat;
  logic [TMO_W-1:0]  mod_rem;

  assign span = (tmo_max_r >= tmo_min_r) ?
                ({1'b0, tmo_max_r} - {1'b0, tmo_min_r} + SPAN_W'(1)) : SPAN_W'(1);

  cle_modu u_modu (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (draw_r),
    .divisor   (span),
    .stat      (mod_stat),
    .remainder (mod_rem)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_min_r <= TIMEOUT_MIN_RST;
      tmo_max_r <= TIMEOUT_MAX_RST;
      own_id_r  <= OWN_ID_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TIMEOUT_MIN: tmo_min_r <= cfg_data;
        CFG_TIMEOUT_MAX: tmo_max_r <= cfg_data;
        CFG_OWN_ID:      own_id_r  <= cfg_data;
        default:         ;
      endcase
    end
  end

  // latch the beat
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r     <= in_tuser;
      peer_r   <= in_tdata[15:0];
      mterm_r  <= in_tdata[47:16];
      cidx_r   <= in_tdata[79:48];
      cterm_r  <= in_tdata[111:80];
      pgrant_r <= in_tdata[112];
      oidx_r   <= in_tdata[144:113];
      oterm_r  <= in_tdata[176:145];
      alive_r  <= in_tdata[181:177];
      draw_r   <= in_tdata[197:182];
    end
  end

  // election rules, evaluated in ST_EVAL
  always_comb begin
    logic log_ok;
    logic [CNT_W-1:0] alive_c;
    role_nxt    = role_r;
    term_nxt    = term_r;
    voted_nxt   = voted_r;
    tally_nxt   = tally_r;
    needed_nxt  = needed_r;
    leader_nxt  = leader_r;
    cdown_nxt   = cdown_r;
    granted_nxt = 1'b0;
    started_nxt = 1'b0;
    changed_nxt = 1'b0;
    rearm       = 1'b0;
    log_ok      = (cterm_r > oterm_r) || ((cterm_r == oterm_r) && (cidx_r >= oidx_r));
    alive_c     = (alive_r > MaxNodes) ? MaxNodes : alive_r;
    case (op_r)
      OP_TICK: begin
        if (role_r != ROLE_LEADER) begin
          if (cdown_r <= TMO_W'(1)) begin
            if (term_r != TERM_MAX) term_nxt = term_r + TERM_W'(1);
            role_nxt    = ROLE_CANDIDATE;
            voted_nxt   = own_id_r;
            tally_nxt   = CNT_W'(1);
            needed_nxt  = (alive_c >> 1) + CNT_W'(1);
            rearm       = 1'b1;
            started_nxt = 1'b1;
            // single-node win on the same tick
            if (CNT_W'(1) >= needed_nxt) begin
              role_nxt    = ROLE_LEADER;
              leader_nxt  = own_id_r;
              changed_nxt = 1'b1;
            end
          end else begin
            cdown_nxt = cdown_r - TMO_W'(1);
          end
        end
      end
      OP_VOTE_REQ: begin
        if (mterm_r >= term_r) begin
          if (mterm_r > term_r) begin
            term_nxt  = mterm_r;
            voted_nxt = '0;
            tally_nxt = '0;
            role_nxt  = ROLE_FOLLOWER;
            rearm     = 1'b1;
          end
          if (((voted_nxt == '0) || (voted_nxt == peer_r)) && log_ok) begin
            voted_nxt   = peer_r;
            granted_nxt = 1'b1;
            rearm       = 1'b1;
          end
        end
      end
      OP_VOTE_RESP: begin
        if (role_r == ROLE_CANDIDATE) begin
          if (mterm_r > term_r) begin
            term_nxt  = mterm_r;
            voted_nxt = '0;
            tally_nxt = '0;
            role_nxt  = ROLE_FOLLOWER;
            rearm     = 1'b1;
          end else if ((mterm_r == term_r) && pgrant_r) begin
            if (tally_r < TALLY_MAX) tally_nxt = tally_r + CNT_W'(1);
            if (tally_nxt >= needed_r) begin
              role_nxt    = ROLE_LEADER;
              leader_nxt  = own_id_r;
              changed_nxt = 1'b1;
            end
          end
        end
      end
      OP_HEARTBEAT: begin
        if (mterm_r > term_r) begin
          term_nxt  = mterm_r;
          voted_nxt = '0;
          tally_nxt = '0;
          role_nxt  = ROLE_FOLLOWER;
        end
        if (mterm_r >= term_r) begin
          if (role_nxt == ROLE_CANDIDATE) role_nxt = ROLE_FOLLOWER;
          if (leader_r != peer_r) begin
            leader_nxt  = peer_r;
            changed_nxt = 1'b1;
          end
          rearm = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = rearm ? ST_MOD : ST_DONE;
      ST_MOD:  if (mod_stat.done) state_nxt = ST_DONE;
      ST_DONE: if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_tready = 1'b0;
    mod_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_EVAL: mod_start = rearm;
      ST_MOD:  ;
      ST_DONE: out_load = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_load) out_tvalid_nxt = 1'b1;
    else if (out_tready) out_tvalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      role_r       <= ROLE_FOLLOWER;
      term_r       <= '0;
      voted_r      <= '0;
      tally_r      <= '0;
      needed_r     <= '0;
      leader_r     <= '0;
      cdown_r      <= TIMEOUT_MIN_RST;
      granted_r    <= 1'b0;
      started_r    <= 1'b0;
      changed_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (state_r == ST_EVAL) begin
        role_r    <= role_nxt;
        term_r    <= term_nxt;
        voted_r   <= voted_nxt;
        tally_r   <= tally_nxt;
        needed_r  <= needed_nxt;
        leader_r  <= leader_nxt;
        cdown_r   <= cdown_nxt;
        granted_r <= granted_nxt;
        started_r <= started_nxt;
        changed_r <= changed_nxt;
      end else if (state_r == ST_MOD && mod_stat.done) begin
        cdown_r <= tmo_min_r + mod_rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {3'b000, changed_r, started_r, granted_r,
                      leader_r, voted_r, term_r, role_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

[sv/cle_modu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_modu - serial remainder unit
// Restoring remainder, one dividend bit per cycle, over all 16 dividend bits.
// ----------------------------------------------------------------------------
module cle_modu (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [cle_pkg::TMO_W-1:0]    dividend,
  input  logic [cle_pkg::SPAN_W-1:0]   divisor,
  output cle_pkg::cle_mod_stat_t       stat,
  output logic [cle_pkg::TMO_W-1:0]    remainder
);
  import cle_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [3:0]          cnt_r, cnt_nxt;
  logic [TMO_W-1:0]    dvd_r, dvd_nxt;
  logic [SPAN_W-1:0]   dvs_r, dvs_nxt;
  logic [TMO_W-1:0]    rem_r, rem_nxt;
  logic [SPAN_W-1:0]   trial;
  logic [SPAN_W-1:0]   diff;

  // remainder stays below divisor, so it fits in 16 bits
  assign trial = {rem_r, dvd_r[TMO_W-1]};
  assign diff  = trial - dvs_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 4'd15;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[TMO_W-2:0], 1'b0};
      rem_nxt = (trial >= dvs_r) ? diff[TMO_W-1:0] : trial[TMO_W-1:0];
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign remainder = rem_r;

endmodule
